FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the splitter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, ignored while reset is held.
`define RRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("splitter assertion failed");

// Implication checked on the next clock edge.
`define RRS_ASSERT_NEXT(lbl, pre, post) \
  `RRS_ASSERT(lbl, (pre) |=> (post))

`endif

FILE: sv/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Types and constants shared by the request splitter modules.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned CHUNK_MIN        = 8;
  localparam int unsigned CHUNK_MAX        = 4096;
  localparam int unsigned DISK_FIELD_LIMIT = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic        LEVEL_RESET = 1'b0;
  localparam logic [4:0]  DISKS_RESET = 5'd2;
  localparam logic [12:0] CHUNK_RESET = 13'd16;

  localparam logic LEVEL_STRIPE = 1'b0;
  localparam logic LEVEL_MIRROR = 1'b1;

  typedef enum logic [1:0] {
    REG_RAID_LEVEL    = 2'd0,
    REG_DISK_COUNT    = 2'd1,
    REG_CHUNK_SECTORS = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_DIV_CHUNK,
    FR_DIV_DISK,
    FR_MUL,
    FR_PUSH
  } front_state_e;

  typedef struct packed {
    logic        level;
    logic [4:0]  disks;
    logic [12:0] chunk;
  } cfg_t;

  // One classified request, ready for the piece generator.
  typedef struct packed {
    logic        level;
    logic        wr;
    logic [8:0]  len;
    logic [31:0] sec;
    logic [12:0] off;
    logic [3:0]  disk;
    logic [31:0] base;
    logic [12:0] chunk;
    logic [4:0]  disks;
  } desc_t;

endpackage

FILE: sv/rrs_queue.sv
// ----------------------------------------------------------------------------
// rrs_queue
// Short descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module rrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrs_pkg::desc_t wr_data_i,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  output rrs_pkg::desc_t rd_data_o,
  output logic           rd_valid_o,
  input  logic           rd_ready_i
);
  import rrs_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CntW'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: sv/rrs_front.sv
// ----------------------------------------------------------------------------
// rrs_front
// Accepts requests, clamps config, runs the chunk and disk divisions.
// ----------------------------------------------------------------------------
module rrs_front #(
  parameter int unsigned MAX_DISKS       = 16,
  parameter int unsigned MAX_REQ_SECTORS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrs_pkg::cfg_t  cfg_i,
  input  logic [31:0]    start_sector_i,
  input  logic [8:0]     length_sectors_i,
  input  logic           is_write_i,
  input  logic           push_i,
  output logic           full_o,
  output rrs_pkg::desc_t desc_o,
  output logic           desc_valid_o,
  input  logic           desc_ready_i
);
  import rrs_pkg::*;

  localparam int unsigned DiskCap  = (MAX_DISKS > DISK_FIELD_LIMIT) ? DISK_FIELD_LIMIT :
                                     ((MAX_DISKS < 1) ? 1 : MAX_DISKS);
  localparam int unsigned DivSteps = 16;  // two quotient bits a cycle over 32 bits

  front_state_e state_q, state_d;
  logic [31:0]  sec_q, dvd_q, base_q;
  logic [8:0]   len_q;
  logic         wr_q, lvl_q;
  logic [4:0]   n_q;
  logic [12:0]  c_q, rem_q, off_q;
  logic [3:0]   disk_q, cnt_q;

  logic [4:0]   n_eff;
  logic [12:0]  c_eff;
  logic [8:0]   len_eff;
  logic         accept;

  logic [12:0]  divisor;
  logic [12:0]  rem_nx;
  logic [31:0]  dvd_nx;
  logic [13:0]  trial;

  // clamp config and length
  always_comb begin
    if (cfg_i.disks == 5'd0) begin
      n_eff = 5'd1;
    end else if (cfg_i.disks > 5'(DiskCap)) begin
      n_eff = 5'(DiskCap);
    end else begin
      n_eff = cfg_i.disks;
    end
    if (cfg_i.chunk < 13'(CHUNK_MIN)) begin
      c_eff = 13'(CHUNK_MIN);
    end else if (cfg_i.chunk > 13'(CHUNK_MAX)) begin
      c_eff = 13'(CHUNK_MAX);
    end else begin
      c_eff = cfg_i.chunk;
    end
    len_eff = (length_sectors_i > 9'(MAX_REQ_SECTORS)) ? 9'(MAX_REQ_SECTORS)
                                                       : length_sectors_i;
  end

  assign full_o = (state_q != FR_IDLE);
  assign accept = push_i && !full_o;

  // restoring divider, two steps per cycle
  always_comb begin
    divisor = (state_q == FR_DIV_DISK) ? {8'd0, n_q} : c_q;
    rem_nx  = rem_q;
    dvd_nx  = dvd_q;
    trial   = '0;
    for (int i = 0; i < 2; i++) begin
      trial  = {rem_nx, dvd_nx[31]};
      dvd_nx = {dvd_nx[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nx    = 13'(trial - {1'b0, divisor});
        dvd_nx[0] = 1'b1;
      end else begin
        rem_nx = trial[12:0];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (accept && len_eff != 9'd0) begin
          state_d = (cfg_i.level == LEVEL_MIRROR) ? FR_PUSH : FR_DIV_CHUNK;
        end
      end
      FR_DIV_CHUNK: if (cnt_q == 4'(DivSteps - 1)) state_d = FR_DIV_DISK;
      FR_DIV_DISK:  if (cnt_q == 4'(DivSteps - 1)) state_d = FR_MUL;
      FR_MUL:       state_d = FR_PUSH;
      FR_PUSH:      if (desc_ready_i) state_d = FR_IDLE;
      default:      state_d = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    desc_valid_o = (state_q == FR_PUSH);
    desc_o.level = lvl_q;
    desc_o.wr    = wr_q;
    desc_o.len   = len_q;
    desc_o.sec   = sec_q;
    desc_o.off   = off_q;
    desc_o.disk  = disk_q;
    desc_o.base  = base_q;
    desc_o.chunk = c_q;
    desc_o.disks = n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FR_DIV_CHUNK || state_q == FR_DIV_DISK) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FR_IDLE: begin
        if (accept) begin
          sec_q <= start_sector_i;
          len_q <= len_eff;
          wr_q  <= is_write_i;
          lvl_q <= cfg_i.level;
          n_q   <= n_eff;
          c_q   <= c_eff;
          dvd_q <= start_sector_i;
          rem_q <= '0;
          // mirror: every piece keeps the logical sector
          base_q <= start_sector_i;
          off_q  <= '0;
          disk_q <= (is_write_i && n_eff > 5'd1) ? 4'd1 : 4'd0;
        end
      end
      FR_DIV_CHUNK: begin
        dvd_q <= dvd_nx;
        rem_q <= rem_nx;
        if (cnt_q == 4'(DivSteps - 1)) begin
          off_q <= rem_nx;
          rem_q <= '0;
        end
      end
      FR_DIV_DISK: begin
        dvd_q <= dvd_nx;
        rem_q <= rem_nx;
        if (cnt_q == 4'(DivSteps - 1)) begin
          disk_q <= rem_nx[3:0];
        end
      end
      FR_MUL: begin
        base_q <= 32'(dvd_q * c_q);
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/rrs_back.sv
// ----------------------------------------------------------------------------
// rrs_back
// Walks one descriptor and emits its member-disk pieces, one per pop.
// ----------------------------------------------------------------------------
module rrs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrs_pkg::desc_t desc_i,
  input  logic           desc_valid_i,
  output logic           desc_ready_o,
  output logic [3:0]     disk_index_o,
  output logic [31:0]    member_sector_o,
  output logic [8:0]     piece_sectors_o,
  output logic           piece_write_o,
  output logic           last_piece_o,
  output logic           empty,
  input  logic           pop
);
  import rrs_pkg::*;

  logic        active_q;
  logic        lvl_q, wr_q;
  logic [8:0]  left_q;
  logic [31:0] sec_q, base_q;
  logic [12:0] off_q, c_q;
  logic [3:0]  disk_q, disk_inc;
  logic [4:0]  n_q;

  logic [12:0] to_bound;
  logic [8:0]  piece_a, piece;
  logic [32:0] sum;
  logic        wrap_hit, disk_wrap, take;

  always_comb begin
    to_bound = c_q - off_q;
    piece_a  = ({4'd0, left_q} < to_bound) ? left_q : to_bound[8:0];
    sum      = {1'b0, sec_q} + {24'd0, piece_a};
    wrap_hit = sum[32];
    // cut where the address wraps to zero
    piece    = (wrap_hit && sum[31:0] != 32'd0) ? 9'(33'h1_0000_0000 - {1'b0, sec_q})
                                                : piece_a;
    disk_wrap = ({1'b0, disk_q} + 5'd1 == n_q);
    disk_inc  = disk_wrap ? 4'd0 : disk_q + 4'd1;
  end

  assign empty           = !active_q;
  assign desc_ready_o    = !active_q;
  assign take            = pop && active_q;
  assign disk_index_o    = disk_q;
  assign member_sector_o = base_q + {19'd0, off_q};
  assign piece_sectors_o = (lvl_q == LEVEL_MIRROR) ? left_q : piece;
  assign piece_write_o   = wr_q;
  assign last_piece_o    = (lvl_q == LEVEL_MIRROR) ? (disk_q == 4'd0) : (piece == left_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (!active_q) begin
      active_q <= desc_valid_i;
    end else if (take && last_piece_o) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!active_q) begin
      lvl_q  <= desc_i.level;
      wr_q   <= desc_i.wr;
      left_q <= desc_i.len;
      sec_q  <= desc_i.sec;
      off_q  <= desc_i.off;
      disk_q <= desc_i.disk;
      base_q <= desc_i.base;
      c_q    <= desc_i.chunk;
      n_q    <= desc_i.disks;
    end else if (take && !last_piece_o) begin
      if (lvl_q == LEVEL_MIRROR) begin
        disk_q <= disk_inc;
      end else begin
        left_q <= left_q - piece;
        off_q  <= '0;
        if (wrap_hit) begin
          sec_q  <= '0;
          disk_q <= '0;
          base_q <= '0;
        end else begin
          sec_q  <= sum[31:0];
          disk_q <= disk_inc;
          if (disk_wrap) begin
            base_q <= base_q + {19'd0, c_q};
          end
        end
      end
    end
  end

endmodule

FILE: sv/raid_request_splitter_unit.sv
// ----------------------------------------------------------------------------
// raid_request_splitter_unit
// Maps block requests onto member-disk pieces for striping or mirroring.
// ----------------------------------------------------------------------------
// Striping: a request is taken, then sector / chunk and chunk number / disks run on
//   the shared two-bit-a-cycle divider, then a multiply step and a queue hop lead to
//   the first piece; one piece per cycle while pop is held.
// Mirroring: the divider and multiply are skipped; one piece per cycle while pop is held.
// A new request is taken once the front end has pushed its descriptor, later if the queue is full.
// Reset (async, active low) empties the pipeline and loads register defaults.
module raid_request_splitter_unit #(
  parameter int unsigned MAX_DISKS       = 16,
  parameter int unsigned MAX_REQ_SECTORS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic [31:0] start_sector_i,
  input  logic [8:0]  length_sectors_i,
  input  logic        is_write_i,
  input  logic        push,
  output logic        full,
  // piece side
  output logic [3:0]  disk_index_o,
  output logic [31:0] member_sector_o,
  output logic [8:0]  piece_sectors_o,
  output logic        piece_write_o,
  output logic        last_piece_o,
  output logic        empty,
  input  logic        pop,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_sel;
  logic     cfg_wr;

  desc_t    fe_desc, be_desc;
  logic     fe_valid, fe_ready, be_valid, be_ready;

  // Registers: write completes in the access phase, no wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level <= LEVEL_RESET;
      cfg_q.disks <= DISKS_RESET;
      cfg_q.chunk <= CHUNK_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_RAID_LEVEL:    cfg_q.level <= pwdata[0];
        REG_DISK_COUNT:    cfg_q.disks <= pwdata[4:0];
        REG_CHUNK_SECTORS: cfg_q.chunk <= pwdata[12:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RAID_LEVEL:    prdata = {31'd0, cfg_q.level};
      REG_DISK_COUNT:    prdata = {27'd0, cfg_q.disks};
      REG_CHUNK_SECTORS: prdata = {19'd0, cfg_q.chunk};
      default:           prdata = '0;
    endcase
  end

  // Front end: clamps, divides, builds one descriptor per request.
  // Zero-length requests are taken and dropped here.
  rrs_front #(
    .MAX_DISKS       (MAX_DISKS),
    .MAX_REQ_SECTORS (MAX_REQ_SECTORS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .start_sector_i   (start_sector_i),
    .length_sectors_i (length_sectors_i),
    .is_write_i       (is_write_i),
    .push_i           (push),
    .full_o           (full),
    .desc_o           (fe_desc),
    .desc_valid_o     (fe_valid),
    .desc_ready_i     (fe_ready)
  );

  // Decoupling queue, lets the divider start on the next request while
  // the back end is still emitting pieces.
  rrs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (fe_desc),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .rd_data_o  (be_desc),
    .rd_valid_o (be_valid),
    .rd_ready_i (be_ready)
  );

  // Back end: piece walk, the held piece doubles as the output register.
  rrs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .desc_i          (be_desc),
    .desc_valid_i    (be_valid),
    .desc_ready_o    (be_ready),
    .disk_index_o    (disk_index_o),
    .member_sector_o (member_sector_o),
    .piece_sectors_o (piece_sectors_o),
    .piece_write_o   (piece_write_o),
    .last_piece_o    (last_piece_o),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

FILE: sv/rrs_checker.sv
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks on the splitter's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [3:0]  disk_index_o,
  input logic [31:0] member_sector_o,
  input logic [8:0]  piece_sectors_o,
  input logic        piece_write_o,
  input logic        last_piece_o,
  input logic        empty,
  input logic        pop
);

  logic [46:0] piece_bits;

  assign piece_bits = {disk_index_o, member_sector_o, piece_sectors_o,
                       piece_write_o, last_piece_o};

  // a stalled piece holds
  `RRS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(piece_bits))

  // every piece carries sectors, never more than a full request
  `RRS_ASSERT(a_len, empty || (piece_sectors_o != 9'd0 && piece_sectors_o <= 9'd256))

  // pieces of one request follow without a gap
  `RRS_ASSERT_NEXT(a_burst, !empty && pop && !last_piece_o, !empty)

  // direction stays fixed across the pieces of a request
  `RRS_ASSERT_NEXT(a_dir, !empty && pop && !last_piece_o, piece_write_o == $past(piece_write_o))

endmodule

bind raid_request_splitter_unit rrs_checker u_rrs_checker (.*);
